### src/swamm_pkg.sv
// Shared types, constants and width helpers for the sliding window average/min/max block.
package swamm_pkg;

  // Window depth is kept a power of two so the mean is a plain shift.
  localparam int WIN_LOG2    = 4;
  localparam int WINDOW      = 1 << WIN_LOG2;
  localparam int SAMPLE_BITS = 32;
  localparam int IN_W        = 32;
  localparam int OUT_W       = 32;
  localparam int IDX_W       = (WIN_LOG2 > 0) ? WIN_LOG2 : 1;
  localparam int SUM_W       = SAMPLE_BITS + WIN_LOG2;
  localparam int INX_W       = (IN_W > SAMPLE_BITS) ? IN_W : SAMPLE_BITS;
  localparam int OUTX_W      = (OUT_W > SAMPLE_BITS) ? OUT_W : SAMPLE_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [IN_W-1:0]        in_word_t;
  typedef logic [OUT_W-1:0]       out_word_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic start;  // clear accumulators for a new item
    logic vld;    // a ring entry is on the read port
  } scan_ctl_t;

  function automatic sample_t to_sample(in_word_t v);
    logic [INX_W-1:0] t;
    t = INX_W'(v);
    return t[SAMPLE_BITS-1:0];
  endfunction

  function automatic out_word_t to_out(sample_t v);
    logic [OUTX_W-1:0] t;
    t = OUTX_W'(v);
    return t[OUT_W-1:0];
  endfunction

endpackage

### src/sliding_window_avg_min_max.sv
// Top level: sliding window mean/min/max over a ring of duration samples.
// A result shows on out_valid once the scan, drain and finish states after the accept have run
// and the output register is free. One ring entry is read and folded per cycle, and in_ready
// comes back the cycle after the result is loaded, so a new item waits until the last retires.
// in_ready stays low while an item is in flight and while a finished result cannot yet retire.
// Reset (rst_n low, synchronous) clears control state and starts a clearing sweep that
// zeroes the ring; in_ready stays low after reset is released until the sweep is done.
module sliding_window_avg_min_max
  import swamm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_sample,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_mean,
  output out_word_t out_window_min,
  output out_word_t out_window_max
);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for an item
  localparam logic [1:0] S_SCAN  = 2'd1;  // issuing one ring read per cycle
  localparam logic [1:0] S_DRAIN = 2'd2;  // last read data folds into the unit
  localparam logic [1:0] S_FIN   = 2'd3;  // hand the result to the output register

  logic [1:0] state_r, state_nxt;
  idx_t       scan_cnt_r, scan_cnt_nxt;
  idx_t       wr_slot_r, wr_slot_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_mean_r, out_min_r, out_max_r;

  logic       in_acc;
  logic       clr_busy;
  logic       rd_en;
  sample_t    rd_data;
  logic       rd_vld;
  scan_ctl_t  scan_ctl;
  sample_t    res_mean, res_min, res_max;
  logic       load_out;

  assign in_ready = (state_r == S_IDLE) && !clr_busy;
  assign in_acc   = in_valid && in_ready;

  // The new sample lands in the ring at the accept edge, so the scan
  // that starts the next cycle already sees it.
  swamm_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_acc),
    .wr_addr  (wr_slot_r),
    .wr_data  (to_sample(in_sample)),
    .rd_en    (rd_en),
    .rd_addr  (scan_cnt_r),
    .rd_data  (rd_data),
    .rd_vld   (rd_vld),
    .clr_busy (clr_busy)
  );

  assign rd_en          = (state_r == S_SCAN);
  assign scan_ctl.start = in_acc;
  assign scan_ctl.vld   = rd_vld;

  swamm_scan u_scan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .data    (rd_data),
    .mean    (res_mean),
    .win_min (res_min),
    .win_max (res_max)
  );

  // Result retires into the output register only once the previous one is gone.
  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    scan_cnt_nxt  = scan_cnt_r;
    wr_slot_nxt   = wr_slot_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt    = S_SCAN;
          scan_cnt_nxt = '0;
          if (wr_slot_r == IDX_W'(WINDOW - 1)) wr_slot_nxt = '0;
          else                                 wr_slot_nxt = wr_slot_r + 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_cnt_r == IDX_W'(WINDOW - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_cnt_r  <= '0;
      wr_slot_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      wr_slot_r   <= wr_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mean_r <= to_out(res_mean);
      out_min_r  <= to_out(res_min);
      out_max_r  <= to_out(res_max);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean       = out_mean_r;
  assign out_window_min = out_min_r;
  assign out_window_max = out_max_r;

endmodule

### src/swamm_ring.sv
// Sample ring memory with registered read port and post-reset clearing sweep.
module swamm_ring
  import swamm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  idx_t    wr_addr,
  input  sample_t wr_data,
  input  logic    rd_en,
  input  idx_t    rd_addr,
  output sample_t rd_data,
  output logic    rd_vld,
  output logic    clr_busy
);

  sample_t mem [WINDOW];
  sample_t rd_data_r;
  logic    rd_vld_r;
  logic    clr_busy_r, clr_busy_nxt;
  idx_t    clr_idx_r, clr_idx_nxt;

  logic    we;
  idx_t    wa;
  sample_t wd;

  // Clearing sweep owns the write port right after reset.
  assign we = clr_busy_r | wr_en;
  assign wa = clr_busy_r ? clr_idx_r : wr_addr;
  assign wd = clr_busy_r ? '0 : wr_data;

  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      if (clr_idx_r == IDX_W'(WINDOW - 1)) begin
        clr_busy_nxt = 1'b0;
        clr_idx_nxt  = '0;
      end else begin
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
      rd_vld_r   <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_vld   = rd_vld_r;
  assign clr_busy = clr_busy_r;

endmodule

### src/swamm_scan.sv
// Shared accumulate/compare unit: running sum, minimum and maximum over the ring.
module swamm_scan
  import swamm_pkg::*;
(
  input  logic      clk,
  input  scan_ctl_t ctl,
  input  sample_t   data,
  output sample_t   mean,
  output sample_t   win_min,
  output sample_t   win_max
);

  sum_t    sum_r, sum_nxt;
  sample_t min_r, min_nxt;
  sample_t max_r, max_nxt;
  sum_t    mean_full;

  always_comb begin
    sum_nxt = sum_r;
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctl.start) begin
      sum_nxt = '0;
      min_nxt = '1;
      max_nxt = '0;
    end else if (ctl.vld) begin
      sum_nxt = sum_r + SUM_W'(data);
      if (data < min_r) min_nxt = data;
      if (data > max_r) max_nxt = data;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    min_r <= min_nxt;
    max_r <= max_nxt;
  end

  // Exact floor of sum / WINDOW; always fits a sample.
  assign mean_full = sum_r >> WIN_LOG2;
  assign mean      = mean_full[SAMPLE_BITS-1:0];
  assign win_min   = min_r;
  assign win_max   = max_r;

endmodule

### src/swamm_checker.sv
// Port-level checker for the sliding window block, with its bind.
module swamm_checker
  import swamm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_sample,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_mean,
  input out_word_t out_window_min,
  input out_word_t out_window_max
);

  // Offered item stays put while the block is busy.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_sample))
    else $error("input item changed while waiting");

  // Held result stays put while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean)
      && $stable(out_window_min) && $stable(out_window_max))
    else $error("result changed while stalled");

  // One item at a time: busy right after an accept.
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // Clearing sweep blocks input after reset.
  a_clear_after_rst: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready during ring clear");

  // Mean lies between min and max.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_window_min <= out_mean) && (out_mean <= out_window_max))
    else $error("mean outside min/max");

endmodule

bind sliding_window_avg_min_max swamm_checker u_swamm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_sample      (in_sample),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_mean       (out_mean),
  .out_window_min (out_window_min),
  .out_window_max (out_window_max)
);

### tb/window_stats_checker.sv
// Checker: predicts window mean/min/max per accepted sample and compares each result.
module window_stats_checker
  import swamm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_sample,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_mean,
  input  out_word_t out_window_min,
  input  out_word_t out_window_max,
  output int        mismatches,
  output int        results_checked,
  output int        results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    out_word_t mean;
    out_word_t lo;
    out_word_t hi;
  } window_stats_t;

  sample_t       ring [WINDOW];
  idx_t          slot;
  window_stats_t pending_stats [$];

  initial begin
    mismatches      = 0;
    results_checked = 0;
    results_pending = 0;
  end

  // Store one sample in the ring, then fold the whole ring.
  function automatic window_stats_t push_sample(in_word_t raw);
    sum_t          total;
    sample_t       lo;
    sample_t       hi;
    window_stats_t r;
    ring[slot] = sample_t'(raw);
    slot = (slot == idx_t'(WINDOW - 1)) ? '0 : slot + 1'b1;
    total = '0;
    lo = ring[0];
    hi = ring[0];
    for (int i = 0; i < WINDOW; i++) begin
      total += ring[i];
      if (ring[i] < lo) lo = ring[i];
      if (ring[i] > hi) hi = ring[i];
    end
    r.mean = out_word_t'(total / WINDOW);
    r.lo   = out_word_t'(lo);
    r.hi   = out_word_t'(hi);
    return r;
  endfunction

  task automatic flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch %0d: %s", $realtime, mismatches, what);
  endtask

  always @(posedge clk) begin
    window_stats_t want;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) ring[i] = '0;
      slot = '0;
      pending_stats.delete();
    end else begin
      // retire first: a result can never belong to the sample taken on the same edge
      if (out_valid && out_ready) begin
        if (pending_stats.size() == 0) begin
          flag($sformatf("result with nothing pending: mean %h min %h max %h",
                         out_mean, out_window_min, out_window_max));
        end else begin
          want = pending_stats.pop_front();
          results_checked++;
          if (want.mean !== out_mean || want.lo !== out_window_min ||
              want.hi !== out_window_max)
            flag($sformatf("mean exp %h got %h, min exp %h got %h, max exp %h got %h",
                           want.mean, out_mean, want.lo, out_window_min,
                           want.hi, out_window_max));
        end
      end
      if (in_valid && in_ready) pending_stats.push_back(push_sample(in_sample));
    end
    results_pending = pending_stats.size();
  end

endmodule

### tb/tb_top.sv
// Testbench top: clock, reset, sample stimulus, receiver stalls and the verdict.
module tb_top;
  import swamm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape
  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 1350;
  localparam int HOLD_AT        = 600;   // samples sent before the long receiver hold-off
  localparam int HOLD_CYCLES    = 400;   // length of that hold-off
  localparam int IDLE_LIMIT     = 3000;  // cycles with no handshake before we give up
  localparam int DRAIN_CYCLES   = 40;    // longer than the block's result latency, catches stray results

  // Receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_sample = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_mean;
  out_word_t out_window_min;
  out_word_t out_window_max;

  int mismatches;
  int results_checked;
  int results_pending;
  int samples_sent = 0;

  sliding_window_avg_min_max dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mean       (out_mean),
    .out_window_min (out_window_min),
    .out_window_max (out_window_max)
  );

  window_stats_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mean        (out_mean),
    .out_window_min  (out_window_min),
    .out_window_max  (out_window_max),
    .mismatches      (mismatches),
    .results_checked (results_checked),
    .results_pending (results_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Present one sample at the falling edge and hold it until the block takes it.
  // Valid stays high on return so back-to-back items need no second assignment.
  task automatic offer_sample(input in_word_t v);
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // Receiver: random stretches of one stall pattern each, plus one long
  // hold-off once the sender is well under way. While held, the single result
  // slot fills and in_ready must drop; the sender keeps offering regardless.
  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       tick;
    bit       held;
    held = 1'b0;
    tick = 0;
    forever begin
      if (!held && samples_sent >= HOLD_AT) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          RX_OPEN:     out_ready <= 1'b1;
          RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
          default:     out_ready <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  // Watchdog: ends the run if no handshake happens on either side for too long.
  // Covers reset, the clearing sweep and the long hold-off with wide margin.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    in_word_t directed [9];
    in_word_t last;
    int       burst;
    int       gap;
    directed = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_000F,
                 32'h0000_0010};

    // Reset once; the block then sweeps its ring clear with in_ready low.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes and bit patterns while the window still holds
    // reset zeros, then a full window of all-ones so the sum runs past 32 bits
    // and mean, min and max all land on the top value.
    foreach (directed[i]) offer_sample(directed[i]);
    repeat (WINDOW) offer_sample('1);
    last = '1;

    // Random: bursts of back-to-back items with random gaps. Values mix full
    // range, small counts (mean remainders matter), near-top values (sum
    // overflow) and repeats (flat windows where min equals max).
    while (samples_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: last = $urandom;
          5, 6:          last = $urandom_range(0, 31);
          7, 8:          last = 32'hFFFF_FFFF - $urandom_range(0, 31);
          default:       last = last;
        endcase
        offer_sample(last);
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid  <= 1'b0;
        in_sample <= $urandom;
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: everything predicted must come back, then a quiet margin.
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d duration samples (%0d directed), checked %0d window results,",
             samples_sent, DIRECTED_ITEMS, results_checked);
    $display("with bursty input, four stall patterns and one %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0 && results_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, results_pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
src/swamm_pkg.sv
src/swamm_ring.sv
src/swamm_scan.sv
src/sliding_window_avg_min_max.sv
src/swamm_checker.sv
tb/window_stats_checker.sv
tb/tb_top.sv
